@@ hdl/lzg_pkg.sv @@
package lzg_pkg;

  // One raw input request as it waits in the front queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } lzg_item_t;

  // What the front queue shows to the back end.
  typedef struct packed {
    logic      valid;
    lzg_item_t item;
  } lzg_queue_status_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_START   = 5'b00010,
    S_SCAN    = 5'b00100,
    S_DECIDE  = 5'b01000,
    S_CONSUME = 5'b10000
  } lzg_state_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MIN_MATCH_W = 6;
  localparam logic [MIN_MATCH_W-1:0] MIN_MATCH_RESET = 6'd4;

endpackage

@@ hdl/lzg_ram.sv @@
module lzg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lzg_queue.sv @@
module lzg_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       end_of_input,
  input  logic                       pop,
  output lzg_pkg::lzg_queue_status_t status
);

  localparam int unsigned PW = $clog2(lzg_pkg::QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(lzg_pkg::QUEUE_DEPTH + 1);

  lzg_pkg::lzg_item_t entry [lzg_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;
  logic          push;
  logic          do_pop;

  assign in_stall = (fill == NW'(lzg_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (fill != '0);

  assign status.valid = (fill != '0);
  assign status.item  = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        entry[wptr].data_byte    <= data_byte;
        entry[wptr].end_of_input <= end_of_input;
        wptr <= (wptr == PW'(lzg_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(lzg_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lzg_engine.sv @@
module lzg_engine #(
  parameter int unsigned WINDOW_BYTES = 4096,
  parameter int unsigned MAX_MATCH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lzg_pkg::MIN_MATCH_W-1:0]     min_match,
  input  lzg_pkg::lzg_queue_status_t          status,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                is_match,
  output logic [7:0]                          literal,
  output logic [$clog2(WINDOW_BYTES)-1:0]     distance,
  output logic [$clog2(MAX_MATCH+1)-1:0]      match_length,
  output logic                                last_token
);

  localparam int unsigned AW   = $clog2(WINDOW_BYTES);
  localparam int unsigned CW   = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned LW   = $clog2(MAX_MATCH + 1);
  localparam int unsigned IW   = $clog2(MAX_MATCH);
  localparam int unsigned CMPW = (LW > lzg_pkg::MIN_MATCH_W) ? LW : lzg_pkg::MIN_MATCH_W;

  lzg_pkg::lzg_state_t state;

  logic [7:0]    la [MAX_MATCH];
  logic [LW-1:0] la_cnt;
  logic          flush;
  logic [CW-1:0] hist_cnt;
  logic [AW-1:0] head;
  logic [AW-1:0] rd_k;
  logic          pipe_v;
  logic [AW-1:0] pipe_k;
  logic [LW-1:0] dcnt;
  logic [LW-1:0] best_len;
  logic [AW-1:0] best_dist;
  logic [LW-1:0] take_cnt;

  logic          lane_v     [MAX_MATCH];
  logic          lane_alive [MAX_MATCH];
  logic [LW-1:0] lane_len   [MAX_MATCH];
  logic [AW-1:0] lane_d     [MAX_MATCH];
  logic          lane_v_next     [MAX_MATCH];
  logic          lane_alive_next [MAX_MATCH];
  logic [LW-1:0] lane_len_next   [MAX_MATCH];
  logic [AW-1:0] lane_d_next     [MAX_MATCH];

  logic [7:0]    rdata;
  logic          issue;
  logic [AW:0]   diff;
  logic [AW-1:0] raddr;
  logic [AW-1:0] limit;
  logic          out_free;
  logic [lzg_pkg::MIN_MATCH_W-1:0] need;
  logic          take_match;
  logic [LW-1:0] take_n;

  lzg_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk   (clk),
    .we    (state == lzg_pkg::S_CONSUME),
    .waddr (head),
    .wdata (la[0]),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign issue = (state == lzg_pkg::S_SCAN) && (rd_k != '0);
  assign diff  = {1'b0, head} - {1'b0, rd_k};
  assign raddr = diff[AW] ? AW'(diff + (AW+1)'(WINDOW_BYTES)) : diff[AW-1:0];
  assign limit = (hist_cnt > CW'(WINDOW_BYTES - 1)) ? AW'(WINDOW_BYTES - 1)
                                                    : hist_cnt[AW-1:0];

  assign pop = (state == lzg_pkg::S_IDLE) && status.valid;

  assign out_free   = !out_valid || !out_stall;
  assign need       = (min_match == '0) ? lzg_pkg::MIN_MATCH_W'(1) : min_match;
  assign take_match = CMPW'(best_len) >= CMPW'(need);
  assign take_n     = take_match ? best_len : LW'(1);

  // Lane j holds the candidate that has compared the byte at offset j.
  always_comb begin
    for (int j = 0; j < MAX_MATCH; j++) begin
      if (j == 0) begin
        lane_v_next[j]     = pipe_v;
        lane_d_next[j]     = pipe_k;
        lane_alive_next[j] = pipe_v && (rdata == la[0]) && (la_cnt != '0);
        lane_len_next[j]   = lane_alive_next[j] ? LW'(1) : '0;
      end else begin
        lane_v_next[j]     = lane_v[j-1];
        lane_d_next[j]     = lane_d[j-1];
        lane_alive_next[j] = pipe_v && lane_alive[j-1] && (rdata == la[j])
                             && (LW'(j) < la_cnt);
        lane_len_next[j]   = lane_len[j-1] + LW'(lane_alive_next[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lzg_pkg::S_IDLE;
      la_cnt    <= '0;
      flush     <= 1'b0;
      hist_cnt  <= '0;
      head      <= '0;
      pipe_v    <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < MAX_MATCH; j++) begin
        lane_v[j] <= 1'b0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        lzg_pkg::S_IDLE: begin
          if (status.valid) begin
            la[la_cnt[IW-1:0]] <= status.item.data_byte;
            la_cnt <= la_cnt + 1'b1;
            flush  <= status.item.end_of_input;
            if (status.item.end_of_input || (la_cnt == LW'(MAX_MATCH - 1))) begin
              state <= lzg_pkg::S_START;
            end
          end
        end
        lzg_pkg::S_START: begin
          rd_k      <= limit;
          pipe_v    <= 1'b0;
          dcnt      <= '0;
          best_len  <= '0;
          best_dist <= '0;
          for (int j = 0; j < MAX_MATCH; j++) begin
            lane_v[j] <= 1'b0;
          end
          state <= lzg_pkg::S_SCAN;
        end
        lzg_pkg::S_SCAN: begin
          pipe_v <= issue;
          pipe_k <= rd_k;
          if (issue) begin
            rd_k <= rd_k - 1'b1;
          end
          for (int j = 0; j < MAX_MATCH; j++) begin
            lane_v[j]     <= lane_v_next[j];
            lane_alive[j] <= lane_alive_next[j];
            lane_len[j]   <= lane_len_next[j];
            lane_d[j]     <= lane_d_next[j];
          end
          // Candidates leave in falling distance order, so >= keeps the nearest.
          if (lane_v[MAX_MATCH-1] && (lane_len[MAX_MATCH-1] >= best_len)) begin
            best_len  <= lane_len[MAX_MATCH-1];
            best_dist <= lane_d[MAX_MATCH-1];
          end
          if (!pipe_v && !issue) begin
            dcnt <= dcnt + 1'b1;
            if (dcnt == LW'(MAX_MATCH - 1)) begin
              state <= lzg_pkg::S_DECIDE;
            end
          end
        end
        lzg_pkg::S_DECIDE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            is_match     <= take_match;
            literal      <= take_match ? 8'd0 : la[0];
            distance     <= take_match ? best_dist : '0;
            match_length <= take_match ? best_len : '0;
            last_token   <= flush && (take_n == la_cnt);
            take_cnt     <= take_n;
            state        <= lzg_pkg::S_CONSUME;
          end
        end
        lzg_pkg::S_CONSUME: begin
          for (int i = 0; i < MAX_MATCH - 1; i++) begin
            la[i] <= la[i+1];
          end
          la_cnt   <= la_cnt - 1'b1;
          take_cnt <= take_cnt - 1'b1;
          head     <= (head == AW'(WINDOW_BYTES - 1)) ? '0 : head + 1'b1;
          if (hist_cnt != CW'(WINDOW_BYTES)) begin
            hist_cnt <= hist_cnt + 1'b1;
          end
          if (take_cnt == LW'(1)) begin
            if (flush) begin
              if (la_cnt == LW'(1)) begin
                hist_cnt <= '0;
                head     <= '0;
                flush    <= 1'b0;
                state    <= lzg_pkg::S_IDLE;
              end else begin
                state <= lzg_pkg::S_START;
              end
            end else begin
              state <= lzg_pkg::S_IDLE;
            end
          end
        end
        default: begin
          state <= lzg_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/lz77_greedy_match_encoder.sv @@
// Greedy LZ77 encoder. Raw bytes come in as requests on the in channel
// (in_valid, in_stall, data_byte, end_of_input); tokens leave as requests on
// the out channel (out_valid, out_stall and the token fields). A token is
// either a literal byte or a (distance, match_length) copy whose source lies
// wholly inside the history window, before the current position.
// Bytes collect in a lookahead of MAX_MATCH bytes. A request that does not
// fill the lookahead and is not the end of the stream gives no token. For
// each token the scan reads every usable history byte (at most
// WINDOW_BYTES-1) one per cycle from the window RAM, and the bytes that the
// token consumes are written back into it one per cycle.
// A request with end_of_input set flushes the whole lookahead as tokens, marks
// the last one with last_token and then starts a fresh, empty history.
// A two-entry front queue takes requests while the back end works; in_stall
// rises only when that queue is full. A token held by out_stall stays in the
// output register while the back end finishes the scan for the next one.
// Reset is synchronous and clears the lookahead and history counts; no
// clearing pass is needed because the history is only read where it has been
// written. The user must write min_match through cfg_write/cfg_data only
// while the block is idle; the block itself does not enforce this. It
// resets to 4.
module lz77_greedy_match_encoder #(
  parameter int unsigned WINDOW_BYTES = 4096,
  parameter int unsigned MAX_MATCH    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lzg_pkg::MIN_MATCH_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  input  logic                              end_of_input,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              is_match,
  output logic [7:0]                        literal,
  output logic [$clog2(WINDOW_BYTES)-1:0]   distance,
  output logic [$clog2(MAX_MATCH+1)-1:0]    match_length,
  output logic                              last_token
);

  // The configured shortest match; a value of 0 acts as 1 in the back end.
  logic [lzg_pkg::MIN_MATCH_W-1:0] min_match;

  // Front queue to back end handshake.
  lzg_pkg::lzg_queue_status_t status;
  logic                       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_match <= lzg_pkg::MIN_MATCH_RESET;
    end else if (cfg_write) begin
      min_match <= cfg_data;
    end
  end

  // The front part buffers raw requests so the input side only stalls when
  // the back end has fallen two requests behind.
  lzg_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .pop          (pop),
    .status       (status)
  );

  // The back part owns the lookahead, the history RAM, the candidate lanes
  // and the output register.
  lzg_engine #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MAX_MATCH    (MAX_MATCH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .min_match    (min_match),
    .status       (status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_match     (is_match),
    .literal      (literal),
    .distance     (distance),
    .match_length (match_length),
    .last_token   (last_token)
  );

endmodule

@@ hdl/lzg_checker.sv @@
module lzg_checker #(
  parameter int unsigned WINDOW_BYTES = 4096,
  parameter int unsigned MAX_MATCH    = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            is_match,
  input logic [7:0]                      literal,
  input logic [$clog2(WINDOW_BYTES)-1:0] distance,
  input logic [$clog2(MAX_MATCH+1)-1:0]  match_length
);

  // A held token stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("token dropped while stalled");

  // A literal never carries copy fields.
  a_literal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_match |-> distance == '0 && match_length == '0)
    else $error("literal token with copy fields");

  // A copy points backward and copies at least one byte, within bounds.
  a_match_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_match |-> distance != '0 && match_length != '0
      && match_length <= ($clog2(MAX_MATCH+1))'(MAX_MATCH)
      && literal == 8'd0)
    else $error("malformed copy token");

  // A copy never reaches into bytes it produces itself.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_match |-> 32'(match_length) <= 32'(distance))
    else $error("copy overlaps its own output");

endmodule

bind lz77_greedy_match_encoder lzg_checker #(
  .WINDOW_BYTES (WINDOW_BYTES),
  .MAX_MATCH    (MAX_MATCH)
) u_lzg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_match     (is_match),
  .literal      (literal),
  .distance     (distance),
  .match_length (match_length)
);
